// ----- design/b64d_pkg.sv -----
// Package for the base64 stream decoder: result codes, decoder phases,
// the command word passed from front to back, and character classifiers.
// Depends on nothing; every other design file imports it.
`default_nettype none

package b64d_pkg;

    // Default number of commands the front-to-back queue can hold.
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Result kind codes as they appear on the kind port.
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // Characters with a special meaning.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    // Sextet offsets of the lower-case and digit ranges, and the two symbols.
    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    // Decoder phase: which sextet is expected next, or where padding stands.
    typedef enum logic [2:0] {
        PH_S1    = 3'd0,
        PH_S2    = 3'd1,
        PH_S3    = 3'd2,
        PH_S4    = 3'd3,
        PH_EQ2   = 3'd4,
        PH_DONE  = 3'd5
    } phase_t;

    // Status result that closes a command, if any.
    typedef enum logic [1:0] {
        ST_NONE = 2'd0,
        ST_END  = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // One command: up to three data bytes from the top, then an optional status.
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  num_data;
        status_t     status;
    } cmd_t;

    // Result of the alphabet lookup.
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    // Space, tab, line feed, vertical tab, form feed and carriage return.
    function automatic logic is_white(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Maps a character of the base64 alphabet to its six-bit value.
    function automatic sextet_t sextet_of(input logic [7:0] c);
        sextet_t r;
        r.ok  = 1'b1;
        r.val = 6'd0;
        if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
            r.val = 6'(c - CHAR_UPPER_A);
        end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) begin
            r.val = 6'(c - CHAR_LOWER_A + LOWER_BASE);
        end else if ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9)) begin
            r.val = 6'(c - CHAR_DIGIT_0 + DIGIT_BASE);
        end else if (c == CHAR_PLUS) begin
            r.val = SEXTET_PLUS;
        end else if (c == CHAR_SLASH) begin
            r.val = SEXTET_SLASH;
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/b64d_front.sv -----
// Front end of the base64 stream decoder: accepts characters, tracks the
// group phase and collected sextets, and issues result commands.
// Depends on b64d_pkg.
`default_nettype none

module b64d_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire logic           full,
    input  wire logic [7:0]     ch,
    input  wire logic           end_of_text,
    output logic                cmd_valid,
    output b64d_pkg::cmd_t      cmd
);
    import b64d_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  held_reg, held_next;
    phase_t      ph;
    logic        accept;
    logic        white;
    sextet_t     sx;
    logic        spare_zero;

    assign accept = push && !full;
    assign white  = is_white(ch);
    assign sx     = sextet_of(ch);

    // The unused low bits of the last sextet must be zero for a clean end.
    assign spare_zero = (held_reg == 2'd1) ? (partial_reg[15:0] == 16'd0)
                                           : (partial_reg[7:0] == 8'd0);

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_S1;
            partial_reg <= 24'd0;
            held_reg    <= 2'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            held_reg    <= held_next;
        end
    end

    // Next state and command for the accepted item.
    always_comb
    begin
        unique case (phase_reg)
            PH_S1, PH_S2, PH_S3, PH_S4, PH_EQ2, PH_DONE: ph = phase_reg;
            default:                                     ph = PH_S1;
        endcase

        phase_next   = phase_reg;
        partial_next = partial_reg;
        held_next    = held_reg;
        cmd_valid    = 1'b0;
        cmd.bytes    = 24'd0;
        cmd.num_data = 2'd0;
        cmd.status   = ST_NONE;

        if (accept)
        begin
            if (end_of_text)
            begin
                // End of text: report and restart at a group boundary.
                cmd_valid = 1'b1;
                if (ph == PH_S1)
                begin
                    cmd.status = ST_END;
                end
                else if ((ph == PH_DONE) && spare_zero)
                begin
                    cmd.bytes    = partial_reg;
                    cmd.num_data = held_reg;
                    cmd.status   = ST_END;
                end
                else
                begin
                    cmd.status = ST_BAD;
                end
                phase_next   = PH_S1;
                partial_next = 24'd0;
                held_next    = 2'd0;
            end
            else if (white)
            begin
                phase_next = ph;
            end
            else if ((ph == PH_DONE) || ((ph == PH_EQ2) && (ch != CHAR_PAD)))
            begin
                // Junk after padding.
                cmd_valid    = 1'b1;
                cmd.status   = ST_BAD;
                phase_next   = PH_S1;
                partial_next = 24'd0;
                held_next    = 2'd0;
            end
            else if (ch == CHAR_PAD)
            begin
                unique case (ph)
                    PH_S3:
                    begin
                        partial_next = {partial_reg[11:0], 12'd0};
                        held_next    = 2'd1;
                        phase_next   = PH_EQ2;
                    end
                    PH_S4:
                    begin
                        partial_next = {partial_reg[17:0], 6'd0};
                        held_next    = 2'd2;
                        phase_next   = PH_DONE;
                    end
                    PH_EQ2:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        // Padding too early in the group.
                        cmd_valid    = 1'b1;
                        cmd.status   = ST_BAD;
                        phase_next   = PH_S1;
                        partial_next = 24'd0;
                        held_next    = 2'd0;
                    end
                endcase
            end
            else if (sx.ok)
            begin
                if (ph == PH_S4)
                begin
                    // Complete group: three bytes at once.
                    cmd_valid    = 1'b1;
                    cmd.bytes    = {partial_reg[17:0], sx.val};
                    cmd.num_data = 2'd3;
                    phase_next   = PH_S1;
                    partial_next = 24'd0;
                    held_next    = 2'd0;
                end
                else
                begin
                    partial_next = {partial_reg[17:0], sx.val};
                    phase_next   = phase_t'(ph + 3'd1);
                end
            end
            else
            begin
                phase_next = ph;
            end
        end
    end

    // A command is issued only for an accepted item.
    a_cmd_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid |-> (push && !full))
        else $error("command issued without an accepted item");

    // End of text always returns the decoder to a group boundary.
    a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_text) |=> ((phase_reg == PH_S1) && (held_reg == 2'd0)))
        else $error("decoder not restarted after end of text");

    // Held bytes exist only while padding is open or complete.
    a_held_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != 2'd0) |-> ((phase_reg == PH_EQ2) || (phase_reg == PH_DONE)))
        else $error("held bytes outside the padding phases");

endmodule

`default_nettype wire

// ----- design/b64d_fifo.sv -----
// Short command queue between the front and the back of the decoder.
// Depends on b64d_pkg for the command type.
`default_nettype none

module b64d_fifo #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire b64d_pkg::cmd_t wr_data,
    input  wire logic           rd_en,
    output b64d_pkg::cmd_t      rd_data,
    output logic                empty,
    output logic                full
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign empty   = (count_reg == CW'(0));
    assign full    = (count_reg == CW'(DEPTH));
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : AW'(wr_ptr_reg + 1'b1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : AW'(rd_ptr_reg + 1'b1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("command queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("command queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("command queue count out of range");

endmodule

`default_nettype wire

// ----- design/b64d_back.sv -----
// Back end of the base64 stream decoder: expands each queued command into
// its result items via an output register, one per cycle while popped.
// Depends on b64d_pkg.
`default_nettype none

module b64d_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire b64d_pkg::cmd_t head,
    input  wire logic           head_empty,
    output logic                head_rd,
    input  wire logic           pop,
    output logic                empty,
    output logic [7:0]          data_byte,
    output logic [1:0]          kind,
    output logic                last
);
    import b64d_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] kind_reg, kind_next;
    logic       last_reg, last_next;
    logic [1:0] idx_reg, idx_next;
    logic [1:0] total;
    logic       load;
    logic       res_last;
    logic [7:0] res_byte;
    logic [1:0] res_kind;

    assign empty     = !out_valid_reg;
    assign data_byte = byte_reg;
    assign kind      = kind_reg;
    assign last      = last_reg;

    // Number of result items in the head command.
    assign total    = 2'(head.num_data + {1'b0, head.status != ST_NONE});
    assign res_last = (idx_reg == 2'(total - 2'd1));
    assign load     = !head_empty && (!out_valid_reg || pop);
    assign head_rd  = load && res_last;

    // Result item at the current position in the head command.
    always_comb
    begin
        res_byte = 8'd0;
        res_kind = KIND_DATA;
        if (idx_reg < head.num_data)
        begin
            case (idx_reg)
                2'd0:    res_byte = head.bytes[23:16];
                2'd1:    res_byte = head.bytes[15:8];
                default: res_byte = head.bytes[7:0];
            endcase
        end
        else
        begin
            unique case (head.status)
                ST_END:  res_kind = KIND_END;
                ST_BAD:  res_kind = KIND_BAD;
                default: res_kind = KIND_DATA;
            endcase
        end
    end

    // Output register and position counter.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        byte_next      = byte_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            byte_next      = res_byte;
            kind_next      = res_kind;
            last_next      = res_last;
            idx_next       = res_last ? 2'd0 : 2'(idx_reg + 2'd1);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    // A partly expanded command stays at the head of the queue.
    a_partial_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> !head_empty)
        else $error("command left the queue before all its items were sent");

    // The final item of a command resets the position counter.
    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (load && res_last) |=> (idx_reg == 2'd0))
        else $error("position counter not cleared after the final item");

    // Status items carry a zero byte.
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg != KIND_DATA)) |-> (byte_reg == 8'd0))
        else $error("status item with nonzero byte");

endmodule

`default_nettype wire

// ----- design/base64_stream_decoder.sv -----
// Base64 stream decoder. One character is taken per item; an item with
// end_of_text set closes the text. Outside padding, whitespace and characters
// outside the alphabet are skipped; each group of four characters gives three
// byte items, and padded groups are held until end of text, where they are
// given with a clean-end status, or replaced by a malformed status. The block
// takes one item per cycle while full is low and gives one result item per
// cycle while pop is held; the front end decodes each character in its cycle
// of acceptance, and the back end expands queued commands at one result per
// cycle while popped, so full rises only when the QUEUE_DEPTH-entry command
// queue is full. Results pass through the queue and the output register.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
`default_nettype none

module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_text,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      data_byte,
    output logic [1:0]      kind,
    output logic            last
);
    import b64d_pkg::*;

    logic cmd_valid;
    cmd_t cmd;
    cmd_t head;
    logic head_empty;
    logic head_rd;

    // Character decoding.
    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ch          (ch),
        .end_of_text (end_of_text),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    // Command queue.
    b64d_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_valid),
        .wr_data (cmd),
        .rd_en   (head_rd),
        .rd_data (head),
        .empty   (head_empty),
        .full    (full)
    );

    // Result expansion.
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_rd    (head_rd),
        .pop        (pop),
        .empty      (empty),
        .data_byte  (data_byte),
        .kind       (kind),
        .last       (last)
    );

endmodule

`default_nettype wire

// ----- bench/base64_stream_decoder_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for base64_stream_decoder: a directed table of characters, then
// random encoded and broken texts, each result checked against a behavioral decoder.
// Depends on b64d_pkg and the base64_stream_decoder design files.

module base64_stream_decoder_test;

    import b64d_pkg::*;

    localparam int RANDOM_ITEMS  = 143;
    localparam int SLOW_SEND_PCT = 37;
    localparam int SLOW_RECV_PCT = 61;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    // Marks a table row that closes with no status result.
    localparam logic [1:0] KIND_NONE = 2'd3;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] kind;
        logic       last;
    } decoded_t;

    // One character item, with its results typed in where typed is set.
    typedef struct packed {
        logic [7:0]  c;
        logic        eot;
        logic        typed;
        logic [1:0]  n_bytes;
        logic [23:0] bytes;
        logic [1:0]  status;
    } text_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] ch;
    logic       end_of_text;
    logic       empty;
    logic       pop;
    logic [7:0] data_byte;
    logic [1:0] kind;
    logic       last;

    // Stimulus control shared by the sender, the receiver and the main sequence.
    text_row_t offer_row;
    text_row_t directed_rows[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    bit        hold_request;
    int        rand_items;

    // Decoder model state, and the results of the item being accepted.
    phase_t      dec_phase;
    logic [23:0] dec_bits;
    logic [1:0]  dec_held;
    logic [7:0]  stage_b[3];
    logic [1:0]  stage_k[3];
    int          stage_n;
    decoded_t    decoded_q[$];

    int errors;
    int items_in;
    int results_out;
    int bytes_out;
    int ends_out;
    int bads_out;
    int full_stalls;
    int cycle_count;

    base64_stream_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .ch          (ch),
        .end_of_text (end_of_text),
        .empty       (empty),
        .pop         (pop),
        .data_byte   (data_byte),
        .kind        (kind),
        .last        (last)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Returns the six-bit value of an alphabet character, or -1 for any other byte.
    function automatic int sextet_value(input logic [7:0] c);
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            return int'(c - CHAR_UPPER_A);
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            return int'(c - CHAR_LOWER_A) + int'(LOWER_BASE);
        if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            return int'(c - CHAR_DIGIT_0) + int'(DIGIT_BASE);
        if (c == CHAR_PLUS)
            return int'(SEXTET_PLUS);
        if (c == CHAR_SLASH)
            return int'(SEXTET_SLASH);
        return -1;
    endfunction

    // Encodes a six-bit value as its alphabet character.
    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        if (v < LOWER_BASE[5:0])
            return CHAR_UPPER_A + 8'(v);
        if (v < DIGIT_BASE[5:0])
            return CHAR_LOWER_A + 8'(v - LOWER_BASE[5:0]);
        if (v < SEXTET_PLUS)
            return CHAR_DIGIT_0 + 8'(v - DIGIT_BASE[5:0]);
        return (v == SEXTET_PLUS) ? CHAR_PLUS : CHAR_SLASH;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // A byte the decoder skips outside padding: whitespace, control or high bytes.
    function automatic logic [7:0] skip_char();
        case ($urandom_range(3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB + 8'($urandom_range(4));
            2: return 8'h80 + 8'($urandom_range(127));
            default: return 8'($urandom_range(8));
        endcase
    endfunction

    function automatic text_row_t plain(input logic [7:0] c, input logic eot);
        text_row_t r;
        r = '0;
        r.c = c;
        r.eot = eot;
        r.status = KIND_NONE;
        return r;
    endfunction

    function automatic text_row_t known(input logic [7:0] c, input logic eot,
                                        input logic [1:0] n, input logic [23:0] b,
                                        input logic [1:0] st);
        text_row_t r;
        r = plain(c, eot);
        r.typed = 1'b1;
        r.n_bytes = n;
        r.bytes = b;
        r.status = st;
        return r;
    endfunction

    task automatic stage_add(input logic [7:0] b, input logic [1:0] k);
        stage_b[stage_n] = b;
        stage_k[stage_n] = k;
        stage_n++;
    endtask

    task automatic restart_decoder();
        dec_phase = PH_S1;
        dec_bits = '0;
        dec_held = '0;
    endtask

    // Steps the decoder model by one character item and stages its results.
    task automatic decode_char(input logic [7:0] c, input logic eot);
        int          v;
        logic [23:0] spare;
        stage_n = 0;
        v = sextet_value(c);
        if (eot) begin
            if (dec_phase == PH_S1) begin
                stage_add(8'h00, KIND_END);
            end else if (dec_phase == PH_DONE) begin
                // Held bytes go out only if the unused low bits are all zero.
                spare = (dec_held == 2'd1) ? 24'h00FFFF : 24'h0000FF;
                if ((dec_bits & spare) == '0) begin
                    stage_add(dec_bits[23:16], KIND_DATA);
                    if (dec_held == 2'd2)
                        stage_add(dec_bits[15:8], KIND_DATA);
                    stage_add(8'h00, KIND_END);
                end else begin
                    stage_add(8'h00, KIND_BAD);
                end
            end else begin
                stage_add(8'h00, KIND_BAD);
            end
            restart_decoder();
        end else if (is_blank(c)) begin
            // Whitespace never changes the state.
        end else if (dec_phase == PH_DONE || (dec_phase == PH_EQ2 && c != CHAR_PAD)) begin
            stage_add(8'h00, KIND_BAD);
            restart_decoder();
        end else if (c == CHAR_PAD) begin
            case (dec_phase)
                PH_S3: begin
                    dec_bits = dec_bits << 12;
                    dec_held = 2'd1;
                    dec_phase = PH_EQ2;
                end
                PH_S4: begin
                    dec_bits = dec_bits << 6;
                    dec_held = 2'd2;
                    dec_phase = PH_DONE;
                end
                PH_EQ2: dec_phase = PH_DONE;
                default: begin
                    stage_add(8'h00, KIND_BAD);
                    restart_decoder();
                end
            endcase
        end else if (v >= 0) begin
            dec_bits = {dec_bits[17:0], 6'(v)};
            if (dec_phase == PH_S4) begin
                stage_add(dec_bits[23:16], KIND_DATA);
                stage_add(dec_bits[15:8], KIND_DATA);
                stage_add(dec_bits[7:0], KIND_DATA);
                restart_decoder();
            end else begin
                dec_phase = phase_t'(dec_phase + 3'd1);
            end
        end
    endtask

    // Offers one item, with random gaps before it, and waits until it is taken.
    task automatic send_row(input text_row_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        ch <= r.c;
        end_of_text <= r.eot;
        offer_row <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic send_char(input logic [7:0] c, input logic eot);
        rand_items++;
        send_row(plain(c, eot));
    endtask

    task automatic send_sextet(input logic [5:0] v);
        if ($urandom_range(6) == 0)
            send_char(skip_char(), 1'b0);
        send_char(sextet_char(v), 1'b0);
    endtask

    // Sends one random text: mostly well formed, some broken, some plain noise.
    task automatic send_message();
        int         pick;
        logic [5:0] v1;
        logic [5:0] v2;
        logic [5:0] v3;
        pick = $urandom_range(99);
        v1 = 6'($urandom_range(63));
        v2 = 6'($urandom_range(63));
        v3 = 6'($urandom_range(63));
        if (pick < 70) begin
            repeat ($urandom_range(3) * 4)
                send_sextet(6'($urandom_range(63)));
            case ($urandom_range(2))
                1: begin
                    // One held byte; the low four bits of the second sextet are unused.
                    if ($urandom_range(9) != 0)
                        v2 = v2 & 6'h30;
                    send_sextet(v1);
                    send_sextet(v2);
                    send_char(CHAR_PAD, 1'b0);
                    if ($urandom_range(2) == 0)
                        send_char(CHAR_SPACE, 1'b0);
                    send_char(CHAR_PAD, 1'b0);
                end
                2: begin
                    // Two held bytes; the low two bits of the third sextet are unused.
                    if ($urandom_range(9) != 0)
                        v3 = v3 & 6'h3C;
                    send_sextet(v1);
                    send_sextet(v2);
                    send_sextet(v3);
                    send_char(CHAR_PAD, 1'b0);
                end
                default: ;
            endcase
            if ($urandom_range(3) == 0)
                send_char(CHAR_TAB + 8'($urandom_range(4)), 1'b0);
            send_char(8'($urandom_range(255)), 1'b1);
        end else if (pick < 85) begin
            // Sextets and padding in arbitrary places, then the end of text.
            repeat ($urandom_range(1, 7)) begin
                case ($urandom_range(9))
                    0, 1, 2: send_char(CHAR_PAD, 1'b0);
                    3: send_char(skip_char(), 1'b0);
                    default: send_char(sextet_char(6'($urandom_range(63))), 1'b0);
                endcase
            end
            send_char(8'($urandom_range(255)), 1'b1);
        end else begin
            repeat ($urandom_range(1, 8))
                send_char(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(1) == 1)
                send_char(8'($urandom_range(255)), 1'b1);
        end
    endtask

    // Predicts the results of every accepted item; typed rows supply their own.
    always @(posedge clk)
    begin
        if (rst_n && push && !full) begin
            decode_char(ch, end_of_text);
            if (offer_row.typed) begin
                stage_n = 0;
                for (int i = 0; i < int'(offer_row.n_bytes); i++)
                    stage_add(8'(offer_row.bytes >> (16 - 8 * i)), KIND_DATA);
                if (offer_row.status != KIND_NONE)
                    stage_add(8'h00, offer_row.status);
            end
            for (int i = 0; i < stage_n; i++)
                decoded_q.push_back({stage_b[i], stage_k[i], i == stage_n - 1});
            items_in++;
        end
        if (rst_n && push && full)
            full_stalls++;
    end

    // Compares each accepted result with the oldest prediction.
    always @(posedge clk)
    begin : check_results
        decoded_t want;
        if (rst_n && pop && !empty) begin
            results_out++;
            if (decoded_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result data_byte %h kind %0d last %0d",
                         $time, data_byte, kind, last);
            end else begin
                want = decoded_q.pop_front();
                if (want.kind == KIND_DATA)
                    bytes_out++;
                else if (want.kind == KIND_END)
                    ends_out++;
                else
                    bads_out++;
                if (data_byte !== want.data_byte) begin
                    errors++;
                    $display("%0t: data_byte expected %h actual %h",
                             $time, want.data_byte, data_byte);
                end
                if (kind !== want.kind) begin
                    errors++;
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
                end
                if (last !== want.last) begin
                    errors++;
                    $display("%0t: last expected %0d actual %0d", $time, want.last, last);
                end
            end
        end
    end

    // Receiver: random idling, and one long hold-off when asked for.
    initial
    begin
        pop = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                pop <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
                hold_request = 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
            $display("base64_stream_decoder_test NOT OK");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random texts in three idling modes, drain.
    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        ch = 8'h00;
        end_of_text = 1'b0;
        offer_row = '0;
        hold_request = 1'b0;
        send_idle_pct = SLOW_SEND_PCT;
        recv_idle_pct = SLOW_RECV_PCT;
        restart_decoder();

        // End of text right after reset, padding first, then a group of all ones.
        directed_rows.push_back(known(CHAR_PAD, 1'b1, 2'd0, 24'h0, KIND_END));
        directed_rows.push_back(known(CHAR_PAD, 1'b0, 2'd0, 24'h0, KIND_BAD));
        directed_rows.push_back(plain("/", 1'b0));
        directed_rows.push_back(plain("/", 1'b0));
        directed_rows.push_back(plain("/", 1'b0));
        directed_rows.push_back(known("/", 1'b0, 2'd3, 24'hFFFFFF, KIND_NONE));
        // Zero and high bytes skipped, whitespace between the two pads, one byte held.
        directed_rows.push_back(plain("A", 1'b0));
        directed_rows.push_back(plain(8'h00, 1'b0));
        directed_rows.push_back(plain(8'hFF, 1'b0));
        directed_rows.push_back(plain("A", 1'b0));
        directed_rows.push_back(plain(CHAR_PAD, 1'b0));
        directed_rows.push_back(plain(CHAR_TAB, 1'b0));
        directed_rows.push_back(plain(CHAR_PAD, 1'b0));
        directed_rows.push_back(known(8'h00, 1'b1, 2'd1, 24'h0, KIND_END));
        // Junk after complete padding.
        directed_rows.push_back(plain("+", 1'b0));
        directed_rows.push_back(plain("z", 1'b0));
        directed_rows.push_back(plain("9", 1'b0));
        directed_rows.push_back(plain(CHAR_PAD, 1'b0));
        directed_rows.push_back(known("q", 1'b0, 2'd0, 24'h0, KIND_BAD));
        // Padding in the second place.
        directed_rows.push_back(plain("Q", 1'b0));
        directed_rows.push_back(known(CHAR_PAD, 1'b0, 2'd0, 24'h0, KIND_BAD));
        // A sextet where the second pad belongs.
        directed_rows.push_back(plain("Q", 1'b0));
        directed_rows.push_back(plain("Q", 1'b0));
        directed_rows.push_back(plain(CHAR_PAD, 1'b0));
        directed_rows.push_back(known("7", 1'b0, 2'd0, 24'h0, KIND_BAD));
        // Truncated group.
        directed_rows.push_back(plain("T", 1'b0));
        directed_rows.push_back(known(CHAR_CR, 1'b1, 2'd0, 24'h0, KIND_BAD));

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_row(directed_rows[i]);

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            if (rand_items >= 2 * RANDOM_ITEMS / 3 && send_idle_pct != 0) begin
                // No idling; the receiver stalls long enough to fill the block.
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_request = 1'b1;
            end else if (rand_items >= RANDOM_ITEMS / 3 && send_idle_pct == SLOW_SEND_PCT) begin
                send_idle_pct = SLOW_RECV_PCT;
                recv_idle_pct = SLOW_SEND_PCT;
            end
            send_message();
        end
        push <= 1'b0;

        do
            @(posedge clk);
        while (decoded_q.size() != 0);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("Sent %0d items (%0d random); got %0d results:", items_in, rand_items,
                 results_out);
        $display("%0d bytes, %0d clean ends, %0d malformed; input held off on %0d cycles.",
                 bytes_out, ends_out, bads_out, full_stalls);
        $display("%0d mismatches.", errors);
        if (errors == 0)
            $display("base64_stream_decoder_test OK");
        else
            $display("base64_stream_decoder_test NOT OK");
        $finish;
    end

endmodule
